FILE: hw/rtl/drfc_pkg.sv
// ----------------------------------------------------------------------------
// drfc_pkg
// Shared types and constants of the record framing checker: walk phases,
// status and mode codes, register indexes and the item structs.
// ----------------------------------------------------------------------------
package drfc_pkg;

  // Width of the saturating record counters
  localparam int unsigned COUNT_WIDTH = 32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_ORDER  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_MODE = 1'd1;
  localparam int unsigned CFG_DATA_W = 2;

  // Record modes: CFI with a zero CIE id, CFI with an all-ones CIE id, units
  localparam logic [1:0] MODE_ZERO_CIE_ID = 2'd0;
  localparam logic [1:0] MODE_ONES_CIE_ID = 2'd1;
  localparam logic [1:0] MODE_UNIT        = 2'd2;

  // Framing constants
  localparam logic [31:0] LEN_ESCAPE     = 32'hFFFF_FFFF;
  localparam logic [63:0] LEN_WIDE_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF - 64'd12;
  localparam logic [3:0]  SHORT_LEN_BYTES = 4'd4;
  localparam logic [3:0]  WIDE_LEN_BYTES  = 4'd8;
  localparam logic [3:0]  ID_BYTES_SHORT  = 4'd4;
  localparam logic [3:0]  ID_BYTES_WIDE   = 4'd8;

  typedef enum logic [2:0] {
    PH_SHORT = 3'd0,
    PH_EXT   = 3'd1,
    PH_ID    = 3'd2,
    PH_BODY  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_BOUNDS = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } drfc_byte_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] cie_tally;
    logic [31:0] fde_tally;
  } drfc_result_t;

endpackage

FILE: hw/rtl/drfc_walker.sv
// ----------------------------------------------------------------------------
// drfc_walker
// Walk state of one section: length fields, id bytes, payload countdown,
// record counters and the sticky error. Advances by one byte per step and
// presents the section result for the step that carries the last byte.
// ----------------------------------------------------------------------------
module drfc_walker
  import drfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  drfc_byte_t   byte_in,
  input  logic         byte_order,
  input  logic [1:0]   record_mode,
  output drfc_result_t result
);

  phase_t           phase_r,   phase_nxt;
  logic [3:0]       idx_r,     idx_nxt;
  logic [63:0]      acc_r,     acc_nxt;
  logic [63:0]      remain_r,  remain_nxt;
  logic             all_zero_r, all_zero_nxt;
  logic             all_ones_r, all_ones_nxt;
  logic             wide_r,    wide_nxt;
  logic [COUNT_WIDTH-1:0] cie_r, cie_nxt;
  logic [COUNT_WIDTH-1:0] fde_r, fde_nxt;
  status_t          err_r,     err_nxt;

  logic        cfi;
  logic [63:0] acc_taken;
  logic [3:0]  idx_inc;
  logic [63:0] remain_dec;
  logic        open_req;
  logic        open_wide;
  logic [63:0] open_len;
  logic [3:0]  open_id_bytes;
  logic        is_cie;
  status_t     fin_err;

  assign cfi = (record_mode == MODE_ZERO_CIE_ID) || (record_mode == MODE_ONES_CIE_ID);

  // Length fields: shift in (big endian) or place by byte lane
  always_comb begin
    if (byte_order) begin
      acc_taken = {acc_r[55:0], byte_in.data_byte};
    end else begin
      acc_taken = acc_r | (64'(byte_in.data_byte) << {idx_r[2:0], 3'b000});
    end
  end

  assign idx_inc    = idx_r + 4'd1;
  assign remain_dec = remain_r - 64'd1;

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    acc_nxt      = acc_r;
    remain_nxt   = remain_r;
    all_zero_nxt = all_zero_r;
    all_ones_nxt = all_ones_r;
    wide_nxt     = wide_r;
    cie_nxt      = cie_r;
    fde_nxt      = fde_r;
    err_nxt      = err_r;
    open_req     = 1'b0;
    open_wide    = 1'b0;
    open_len     = acc_taken;
    is_cie       = 1'b0;

    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_SHORT: begin
          acc_nxt = acc_taken;
          idx_nxt = idx_inc;
          if (idx_inc >= SHORT_LEN_BYTES) begin
            acc_nxt = {32'd0, acc_taken[31:0]};
            open_len = {32'd0, acc_taken[31:0]};
            if (acc_taken[31:0] == 32'd0) begin
              if (cfi) begin
                phase_nxt = PH_TRAIL;
              end else begin
                err_nxt = ST_FORMAT;
              end
            end else if (acc_taken[31:0] == LEN_ESCAPE) begin
              phase_nxt = PH_EXT;
              idx_nxt   = 4'd0;
              acc_nxt   = 64'd0;
              wide_nxt  = 1'b1;
            end else begin
              wide_nxt  = 1'b0;
              open_req  = 1'b1;
              open_wide = 1'b0;
            end
          end
        end
        PH_EXT: begin
          acc_nxt = acc_taken;
          idx_nxt = idx_inc;
          if (idx_inc >= WIDE_LEN_BYTES) begin
            if (cfi && (acc_taken < 64'(WIDE_LEN_BYTES))) begin
              err_nxt = ST_FORMAT;
            end else if (acc_taken > LEN_WIDE_LIMIT) begin
              err_nxt = ST_BOUNDS;
            end else begin
              open_req  = 1'b1;
              open_wide = wide_r;
            end
          end
        end
        PH_ID: begin
          remain_nxt   = remain_dec;
          all_zero_nxt = all_zero_r && (byte_in.data_byte == 8'h00);
          all_ones_nxt = all_ones_r && (byte_in.data_byte == 8'hFF);
          idx_nxt      = idx_inc;
          if (idx_inc >= (wide_r ? ID_BYTES_WIDE : ID_BYTES_SHORT)) begin
            is_cie = (record_mode == MODE_ONES_CIE_ID) ? all_ones_nxt : all_zero_nxt;
            if (is_cie) begin
              if (cie_r != COUNT_MAX) cie_nxt = cie_r + 1'b1;
            end else begin
              if (fde_r != COUNT_MAX) fde_nxt = fde_r + 1'b1;
            end
            phase_nxt = PH_BODY;
            if (remain_dec == 64'd0) begin
              phase_nxt = PH_SHORT;
              idx_nxt   = 4'd0;
              acc_nxt   = 64'd0;
            end
          end
        end
        PH_BODY: begin
          remain_nxt = remain_dec;
          if (remain_dec == 64'd0) begin
            phase_nxt = PH_SHORT;
            idx_nxt   = 4'd0;
            acc_nxt   = 64'd0;
          end
        end
        PH_TRAIL: begin
          if (byte_in.data_byte != 8'h00) err_nxt = ST_FORMAT;
        end
        default: begin
          err_nxt = ST_FORMAT;
        end
      endcase
    end

    // Open the payload of a record once its length is complete
    open_id_bytes = open_wide ? ID_BYTES_WIDE : ID_BYTES_SHORT;
    if (open_req) begin
      if (cfi && (open_len < 64'(open_id_bytes))) begin
        err_nxt = ST_FORMAT;
      end else begin
        phase_nxt    = cfi ? PH_ID : PH_BODY;
        remain_nxt   = open_len;
        idx_nxt      = 4'd0;
        all_zero_nxt = 1'b1;
        all_ones_nxt = 1'b1;
        if (open_len == 64'd0) begin
          phase_nxt = PH_SHORT;
          acc_nxt   = 64'd0;
        end
      end
    end
  end

  // End-of-section checks on the state after the last byte
  always_comb begin
    fin_err = err_nxt;
    if (err_nxt == ST_OK) begin
      if (phase_nxt == PH_SHORT) begin
        if ((idx_nxt != 4'd0) && (!cfi || (acc_nxt != 64'd0))) fin_err = ST_FORMAT;
      end else if (phase_nxt != PH_TRAIL) begin
        fin_err = ST_FORMAT;
      end
    end
    result.status    = fin_err;
    result.cie_tally = ((fin_err == ST_OK) && cfi) ? 32'(cie_nxt) : 32'd0;
    result.fde_tally = ((fin_err == ST_OK) && cfi) ? 32'(fde_nxt) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && byte_in.last)) begin
      phase_r    <= PH_SHORT;
      idx_r      <= 4'd0;
      acc_r      <= 64'd0;
      remain_r   <= 64'd0;
      all_zero_r <= 1'b1;
      all_ones_r <= 1'b1;
      wide_r     <= 1'b0;
      cie_r      <= '0;
      fde_r      <= '0;
      err_r      <= ST_OK;
    end else if (step) begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      acc_r      <= acc_nxt;
      remain_r   <= remain_nxt;
      all_zero_r <= all_zero_nxt;
      all_ones_r <= all_ones_nxt;
      wide_r     <= wide_nxt;
      cie_r      <= cie_nxt;
      fde_r      <= fde_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

FILE: hw/rtl/dwarf_record_framing_checker.sv
// Flow: a section byte is accepted into the input register and applied from there;
//   the result for a last byte is loaded, once the result slot is free, into the result register that drives out_*.
// Throughput: one byte per cycle, but a last byte waits while the result slot is occupied; the walk state update
//   (64-bit countdown and compare) between the input register and the state/result registers sets it.
// Reset: synchronous, active low; clears the walk, the counters and both
//   registers (byte_order little endian, record_mode CFI with a zero CIE id).
// ----------------------------------------------------------------------------
// dwarf_record_framing_checker
// Walks the length-prefixed records of a section, one byte per item, and
// reports status and CIE/FDE counts on the last byte of the section.
// ----------------------------------------------------------------------------
module dwarf_record_framing_checker
  import drfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // section bytes
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last,
  // results
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [31:0]            out_cie_tally,
  output logic [31:0]            out_fde_tally,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic         byte_order_r,  byte_order_nxt;
  logic [1:0]   record_mode_r, record_mode_nxt;

  logic         s1_valid_r, s1_valid_nxt;
  drfc_byte_t   s1_byte_r;
  logic         advance;

  logic         out_valid_r, out_valid_nxt;
  drfc_result_t out_r;
  drfc_result_t walk_result;

  // Configuration: always ready; the user writes it only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_comb begin
    byte_order_nxt  = byte_order_r;
    record_mode_nxt = record_mode_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BYTE_ORDER:  byte_order_nxt  = cfg_data[0];
        CFG_RECORD_MODE: record_mode_nxt = cfg_data[1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r  <= 1'b0;
      record_mode_r <= MODE_ZERO_CIE_ID;
    end else begin
      byte_order_r  <= byte_order_nxt;
      record_mode_r <= record_mode_nxt;
    end
  end

  // Input register: a held byte advances unless it is a last byte whose
  // result slot is still occupied and not being taken
  assign advance  = s1_valid_r && (!s1_byte_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Hold the payload of the accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r.data_byte <= in_data_byte;
      s1_byte_r.last      <= in_last;
    end
  end

  drfc_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .byte_in     (s1_byte_r),
    .byte_order  (byte_order_r),
    .record_mode (record_mode_r),
    .result      (walk_result)
  );

  // Result register: load on the last byte, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && s1_byte_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_byte_r.last) begin
      out_r <= walk_result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_cie_tally = out_r.cie_tally;
  assign out_fde_tally = out_r.fde_tally;

endmodule

FILE: hw/rtl/drfc_checker.sv
// ----------------------------------------------------------------------------
// drfc_checker
// Port-level checks of the record framing checker, bound to the top level.
// ----------------------------------------------------------------------------
module drfc_checker
  import drfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_cie_tally,
  input logic [31:0] out_fde_tally
);

  // An error result never carries counts
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_cie_tally == 32'd0) &&
                                              (out_fde_tally == 32'd0)))
    else $error("error result with nonzero counts");

  // A fresh result follows an accepted last byte, through the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && $past(rst_n, 2)) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a matching last byte");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
                                   $stable(out_cie_tally) && $stable(out_fde_tally)))
    else $error("stalled result changed");

  // Reset empties the result slot
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind dwarf_record_framing_checker drfc_checker u_drfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_cie_tally (out_cie_tally),
  .out_fde_tally (out_fde_tally)
);
